// ===== hw/rtl/mrtu_pkg.sv =====
`timescale 1ns / 1ps
package mrtu_pkg;

    localparam int REG_COUNT_DEF        = 16;
    localparam int HIGHEST_REG_ADDR_DEF = 15;
    localparam int HDR_LEN              = 7;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

    // function codes
    localparam t_byte FN_READ_HOLD    = 8'h03;
    localparam t_byte FN_WRITE_SINGLE = 8'h06;
    localparam t_byte FN_WRITE_MULTI  = 8'h10;
    localparam t_byte FN_EXC_FLAG     = 8'h80;

    // exception codes
    localparam t_byte EXC_NONE          = 8'd0;
    localparam t_byte EXC_ILLEGAL_FUNC  = 8'd1;
    localparam t_byte EXC_ILLEGAL_ADDR  = 8'd2;
    localparam t_byte EXC_ILLEGAL_VALUE = 8'd3;

    localparam t_word CRC_POLY = 16'hA001;
    localparam t_word CRC_INIT = 16'hFFFF;

    // configuration register indexes
    localparam int   CFG_IDX_W      = 1;
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_MAX_WRITE  = 1'b1;

    localparam t_byte SLAVE_ADDR_RST = 8'd1;
    localparam t_word MAX_WRITE_RST  = 16'hFFFF;
    localparam t_byte POS_MAX        = 8'd255;

    typedef struct packed {
        logic  init;
        logic  load;
        t_byte data;
    } t_crc_ctl;

endpackage

// ===== hw/rtl/mrtu_rx_if.sv =====
`timescale 1ns / 1ps
interface mrtu_rx_if import mrtu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== hw/rtl/mrtu_tx_if.sv =====
`timescale 1ns / 1ps
interface mrtu_tx_if import mrtu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte tx_byte;
    logic  tx_last;

    modport source (output valid, output tx_byte, output tx_last, input ready);
    modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ===== hw/rtl/mrtu_crc.sv =====
`timescale 1ns / 1ps
module mrtu_crc import mrtu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_crc_ctl i_ctl,
    output logic     o_busy,
    output t_word    o_crc
);

    t_word      r_crc;
    logic [2:0] r_cnt;
    logic       r_busy;
    t_word      shifted;

    // one bit of the reflected CRC per cycle
    assign shifted = (r_crc >> 1) ^ (r_crc[0] ? CRC_POLY : 16'h0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else if (i_ctl.init) begin
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else if (i_ctl.load) begin
            r_crc  <= r_crc ^ {8'h00, i_ctl.data};
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_crc <= shifted;
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_crc  = r_crc;

    a_eight_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ##7 r_busy ##1 !r_busy)
        else $error("crc unit did not finish after eight shifts");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> !r_busy)
        else $error("crc load while shifting");

    a_init_load_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.init && i_ctl.load))
        else $error("crc init and load together");

endmodule

// ===== hw/rtl/modbus_rtu_slave_register_server.sv =====
`timescale 1ns / 1ps
// Request word: taken only in S_IDLE; S_POST follows, then S_IDLE again unless it ended the frame.
// Response: after the frame-end word is accepted, S_POST sets up the answer; each body
// word then passes S_LOAD (load), S_CRC (8 steps of the bit-serial CRC unit) and S_SEND
// (hand-off), plus any stall; the two CRC words follow. No request taken while answering.
// Synchronous reset clears the register file and frame state, slave address to 1,
// write limit to 0xFFFF.
module modbus_rtu_slave_register_server import mrtu_pkg::*; #(
    parameter int REG_COUNT        = REG_COUNT_DEF,
    parameter int HIGHEST_REG_ADDR = HIGHEST_REG_ADDR_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mrtu_rx_if.sink              i_rx,
    mrtu_tx_if.source            o_tx,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_word                i_cfg_data
);

    localparam int IDX_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int BODY_MAX = 3 + 2 * REG_COUNT;
    localparam int KW       = $clog2(BODY_MAX + 1);

    localparam logic [15:0] REG_COUNT_W = 16'(REG_COUNT);
    localparam logic [16:0] REG_COUNT_X = 17'(REG_COUNT);
    localparam logic [15:0] HIGH_W      = 16'(HIGHEST_REG_ADDR);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POST   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_CRC    = 3'd3;
    localparam logic [2:0] S_SEND   = 3'd4;
    localparam logic [2:0] S_CRC_LO = 3'd5;
    localparam logic [2:0] S_CRC_HI = 3'd6;

    localparam logic [1:0] K_EXC  = 2'd0;
    localparam logic [1:0] K_READ = 2'd1;
    localparam logic [1:0] K_ECHO = 2'd2;

    logic [2:0]  r_state, n_state;
    t_word       r_regs [REG_COUNT];
    t_byte       r_hdr  [HDR_LEN];
    t_byte       r_pos;
    logic        r_wr_allowed;
    t_byte       r_pending;
    logic        r_end;
    logic        r_at6;
    t_byte       r_slave;
    t_word       r_max;
    logic [1:0]  r_kind;
    t_byte       r_code;
    logic [KW-1:0] r_len;
    logic [KW-1:0] r_k;
    t_byte       r_tx;

    t_crc_ctl    crc_ctl;
    logic        crc_busy;
    t_word       crc_val;

    logic        rx_acc, tx_acc;
    t_word       hdr_a, hdr_n;
    logic        n_bad, bc_bad, addr_bad;
    t_byte       rc_plain, rc_bc;
    t_byte       data_off;
    logic [6:0]  data_word;
    logic        store_ok;
    logic        wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_word       wr_data;
    logic [16:0] data_sum;
    logic [KW-1:0] k_off;
    logic [IDX_W+KW-1:0] rd_sum;
    t_word       rd_word;
    t_byte       resp_byte;
    logic        fn6_ok;

    assign rx_acc     = i_rx.valid && i_rx.ready;
    assign tx_acc     = o_tx.valid && o_tx.ready;
    assign i_rx.ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign hdr_a = {r_hdr[2], r_hdr[3]};
    assign hdr_n = {r_hdr[4], r_hdr[5]};

    // range checks shared by read, multiple-write and the write gate
    assign n_bad    = (hdr_n == 16'd0) || (hdr_n > REG_COUNT_W);
    assign bc_bad   = {9'd0, r_hdr[6]} != {hdr_n, 1'b0};
    assign addr_bad = (hdr_a > HIGH_W) || (({1'b0, hdr_a} + {1'b0, hdr_n}) > REG_COUNT_X);
    assign rc_plain = n_bad ? EXC_ILLEGAL_VALUE : (addr_bad ? EXC_ILLEGAL_ADDR : EXC_NONE);
    assign rc_bc    = (n_bad || bc_bad) ? EXC_ILLEGAL_VALUE
                    : (addr_bad ? EXC_ILLEGAL_ADDR : EXC_NONE);

    assign fn6_ok = (hdr_n <= r_max) && (hdr_a <= HIGH_W) && (hdr_a < REG_COUNT_W);

    // multiple-write data words
    assign data_off  = r_pos - 8'(HDR_LEN);
    assign data_word = data_off[7:1];
    assign data_sum  = {1'b0, hdr_a} + {10'd0, data_word};
    assign store_ok  = ({9'd0, data_word} < hdr_n) && (data_sum < REG_COUNT_X);

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = data_sum[IDX_W-1:0];
        wr_data = {r_pending, i_rx.rx_byte};
        if (r_state == S_IDLE) begin
            wr_en = rx_acc && (r_pos >= 8'(HDR_LEN)) && r_wr_allowed && data_off[0] && store_ok;
        end else if (r_state == S_POST) begin
            wr_en   = r_end && (r_hdr[1] == FN_WRITE_SINGLE) && fn6_ok;
            wr_idx  = hdr_a[IDX_W-1:0];
            wr_data = hdr_n;
        end
    end

    // response body byte r_k
    assign k_off   = r_k - KW'(3);
    assign rd_sum  = {{KW{1'b0}}, hdr_a[IDX_W-1:0]} + {{(IDX_W+1){1'b0}}, k_off[KW-1:1]};
    assign rd_word = r_regs[rd_sum[IDX_W-1:0]];

    always_comb begin
        resp_byte = r_slave;
        if (r_k != '0) begin
            case (r_kind)
                K_EXC: begin
                    resp_byte = (r_k == KW'(1)) ? (r_hdr[1] | FN_EXC_FLAG) : r_code;
                end
                K_READ: begin
                    if (r_k == KW'(1)) begin
                        resp_byte = FN_READ_HOLD;
                    end else if (r_k == KW'(2)) begin
                        resp_byte = {hdr_n[6:0], 1'b0};
                    end else begin
                        resp_byte = r_k[0] ? rd_word[15:8] : rd_word[7:0];
                    end
                end
                K_ECHO: begin
                    resp_byte = r_hdr[r_k[2:0]];
                end
                default: resp_byte = r_slave;
            endcase
        end
    end

    always_comb begin
        crc_ctl.init = (r_state == S_POST) && r_end;
        crc_ctl.load = (r_state == S_LOAD);
        crc_ctl.data = resp_byte;
    end

    mrtu_crc u_crc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (crc_ctl),
        .o_busy (crc_busy),
        .o_crc  (crc_val)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (rx_acc) n_state = S_POST;
            S_POST:   n_state = r_end ? S_LOAD : S_IDLE;
            S_LOAD:   n_state = S_CRC;
            S_CRC:    if (!crc_busy) n_state = S_SEND;
            S_SEND:   if (tx_acc) n_state = (r_k == r_len - KW'(1)) ? S_CRC_LO : S_LOAD;
            S_CRC_LO: if (tx_acc) n_state = S_CRC_HI;
            S_CRC_HI: if (tx_acc) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_wr_allowed <= 1'b0;
            r_pending    <= '0;
            r_end        <= 1'b0;
            r_at6        <= 1'b0;
            r_slave      <= SLAVE_ADDR_RST;
            r_max        <= MAX_WRITE_RST;
            r_kind       <= K_EXC;
            r_code       <= EXC_NONE;
            r_len        <= '0;
            r_k          <= '0;
            r_tx         <= '0;
            for (int i = 0; i < HDR_LEN; i++) begin
                r_hdr[i] <= '0;
            end
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLAVE_ADDR: r_slave <= i_cfg_data[7:0];
                    CFG_MAX_WRITE:  r_max   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (wr_en) begin
                r_regs[wr_idx] <= wr_data;
            end

            case (r_state)
                S_IDLE: begin
                    if (rx_acc) begin
                        r_end <= i_rx.frame_end;
                        r_at6 <= (r_pos == 8'(HDR_LEN - 1));
                        if (r_pos < 8'(HDR_LEN)) begin
                            r_hdr[r_pos[2:0]] <= i_rx.rx_byte;
                        end else if (r_wr_allowed && !data_off[0]) begin
                            r_pending <= i_rx.rx_byte;
                        end
                        if (r_pos != POS_MAX) begin
                            r_pos <= r_pos + 8'd1;
                        end
                    end
                end
                S_POST: begin
                    if (r_at6) begin
                        r_wr_allowed <= (r_hdr[1] == FN_WRITE_MULTI) && (rc_bc == EXC_NONE);
                    end
                    if (r_end) begin
                        r_k    <= '0;
                        r_kind <= K_EXC;
                        r_len  <= KW'(3);
                        case (r_hdr[1])
                            FN_READ_HOLD: begin
                                r_code <= rc_plain;
                                if (rc_plain == EXC_NONE) begin
                                    r_kind <= K_READ;
                                    r_len  <= KW'(3) + KW'({hdr_n, 1'b0});
                                end
                            end
                            FN_WRITE_SINGLE: begin
                                r_code <= (hdr_n > r_max) ? EXC_ILLEGAL_VALUE : EXC_ILLEGAL_ADDR;
                                if (fn6_ok) begin
                                    r_kind <= K_ECHO;
                                    r_len  <= KW'(6);
                                end
                            end
                            FN_WRITE_MULTI: begin
                                r_code <= rc_bc;
                                if (rc_bc == EXC_NONE) begin
                                    r_kind <= K_ECHO;
                                    r_len  <= KW'(6);
                                end
                            end
                            default: r_code <= EXC_ILLEGAL_FUNC;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_tx <= resp_byte;
                end
                S_SEND: begin
                    if (tx_acc) begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_CRC_HI: begin
                    if (tx_acc) begin
                        // frame done: back to a clean frame state
                        r_pos        <= '0;
                        r_wr_allowed <= 1'b0;
                        r_pending    <= '0;
                        for (int i = 0; i < HDR_LEN; i++) begin
                            r_hdr[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_tx.valid   = (r_state == S_SEND) || (r_state == S_CRC_LO) || (r_state == S_CRC_HI);
    assign o_tx.tx_last = (r_state == S_CRC_HI);
    assign o_tx.tx_byte = (r_state == S_CRC_LO) ? crc_val[7:0]
                        : ((r_state == S_CRC_HI) ? crc_val[15:8] : r_tx);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx.valid |-> !i_rx.ready)
        else $error("request taken while answering");

    a_gate_fn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_allowed |-> (r_hdr[1] == FN_WRITE_MULTI))
        else $error("data write gate open for wrong function");

    a_crc_to_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC) && !crc_busy |=> (r_state == S_SEND))
        else $error("body word not presented after crc step");

    a_crc_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC_LO) |-> !crc_busy)
        else $error("crc still running at crc output");

endmodule
